### src/indexed_binary_heap_queue_macros.svh
// Assertion macros for the heap queue checker
`ifndef INDEXED_BINARY_HEAP_QUEUE_MACROS_SVH
`define INDEXED_BINARY_HEAP_QUEUE_MACROS_SVH
`define IBHQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IBHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### src/ibhq_pkg.sv
// Package: constants, types and codes of the indexed heap queue
`default_nettype none
package ibhq_pkg;
  localparam int Capacity = 64;
  localparam int KeyBits = 32;
  localparam int SlotBits = $clog2(Capacity + 1);
  localparam int IdBits = 7;
  localparam int AddrBits = $clog2(Capacity);

  typedef logic [1:0] req_t;
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_POP = 2'd1;
  localparam req_t REQ_INVERT = 2'd2;
  localparam req_t REQ_QUERY = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_DUP = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAPRD, S_DECIDE, S_POPLAST, S_POPMAP, S_UPRD, S_UPCMP,
    S_DNRD, S_DNCMP, S_SWAP, S_INVNEXT, S_RESULT
  } state_t;
endpackage
`default_nettype wire

### src/indexed_binary_heap_queue.sv
// Top level: indexed binary heap priority queue with a sequenced sift engine
//
// One request at a time. After reset a clearing pass empties every entry of the
// id-to-slot map before input is ready. Query, refused insert and empty pop go
// straight to the result; insert sifts the new entry up level by level until it
// reaches the root or stops below it; pop moves the last entry to the root and
// sifts it down level by level. Invert sifts down every internal node bottom-up.
// Input is not ready while a request is in work; a finished result waits only
// while the previous beat is still unread in the output register.
`default_nettype none
module indexed_binary_heap_queue
  import ibhq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // req_type[1:0], entry_id[8:2], entry_key[40:9]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata   // status, top_id, top_key, is_empty, entry_count,
                                     // max_order, query_found, query_key
);
  state_t state, state_next;

  logic [IdBits-1:0]   id_mem [Capacity];
  logic [KeyBits-1:0]  key_mem [Capacity];
  logic [SlotBits-1:0] map_mem [Capacity+1];

  req_t req;
  logic [IdBits-1:0] rid;
  logic [KeyBits-1:0] rkey;
  logic [SlotBits-1:0] count, cur, chl, lim;
  logic order_max;
  logic [IdBits-1:0] aid, bid, cid;
  logic [KeyBits-1:0] akey, bkey, ckey;
  logic [SlotBits-1:0] mslot;
  logic [SlotBits-1:0] clr_idx;
  logic [1:0] phase;
  status_t status;
  logic qfound;
  logic [KeyBits-1:0] qkey;
  logic [87:0] out_data;
  logic res_load;

  // shared compare unit: x ranks above y
  function automatic logic above(input logic om, input logic [KeyBits-1:0] x,
                                 input logic [KeyBits-1:0] y);
    return om ? (x > y) : (x < y);
  endfunction

  assign s_tready = (state == S_IDLE);
  assign res_load = (state == S_RESULT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == SlotBits'(Capacity)) state_next = S_IDLE;
      S_IDLE: if (s_tvalid && s_tready) state_next = S_MAPRD;
      S_MAPRD: state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = S_RESULT;
        case (req)
          REQ_INSERT: if (count < SlotBits'(Capacity) && rid <= IdBits'(Capacity)
                          && mslot == '0) state_next = S_UPRD;
          REQ_POP: if (count != '0) state_next = S_POPLAST;
          REQ_INVERT: if ((count >> 1) != '0) state_next = S_DNRD;
          default: state_next = S_RESULT;
        endcase
      end
      S_POPLAST: state_next = S_POPMAP;
      S_POPMAP: state_next = S_DNRD;
      S_UPRD: state_next = (cur <= SlotBits'(1)) ? S_RESULT : S_UPCMP;
      S_UPCMP: state_next = above(order_max, akey, bkey) ? S_SWAP : S_RESULT;
      S_DNRD: begin
        case (phase)
          2'd0: if ({cur, 1'b0} > {1'b0, count}) state_next = S_INVNEXT;
          2'd1: if (!({cur, 1'b0} < {1'b0, count})) state_next = S_DNCMP;
          2'd2: state_next = S_DNRD;
          default: state_next = S_DNCMP;
        endcase
      end
      S_DNCMP: state_next = above(order_max, bkey, akey) ? S_SWAP : S_INVNEXT;
      S_SWAP: state_next = (req == REQ_INSERT) ? S_UPRD : S_DNRD;
      S_INVNEXT: state_next = (req == REQ_INVERT && lim > SlotBits'(1)) ? S_DNRD : S_RESULT;
      S_RESULT: if (res_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer datapath: one compare per step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      count <= '0;
      order_max <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          map_mem[clr_idx] <= '0;
          clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: if (s_tvalid && s_tready) begin
          req <= s_tdata[1:0];
          rid <= s_tdata[8:2];
          rkey <= s_tdata[40:9];
          status <= ST_DONE;
          qfound <= 1'b0;
          qkey <= '0;
          phase <= '0;
        end
        S_MAPRD: begin
          mslot <= (rid <= IdBits'(Capacity)) ? map_mem[rid] : '0;
        end
        S_DECIDE: begin
          case (req)
            REQ_INSERT: if (count >= SlotBits'(Capacity)) status <= ST_FULL;
              else if (rid <= IdBits'(Capacity)) begin
                if (mslot != '0) status <= ST_DUP;
                else begin
                  count <= count + 1'b1;
                  cur <= count + 1'b1;
                  id_mem[AddrBits'(count)] <= rid;
                  key_mem[AddrBits'(count)] <= rkey;
                  map_mem[rid] <= count + 1'b1;
                  akey <= rkey;
                  aid <= rid;
                end
              end
            REQ_POP: if (count != '0) begin
              bid <= id_mem[0];
              cid <= id_mem[AddrBits'(count - 1'b1)];
              ckey <= key_mem[AddrBits'(count - 1'b1)];
            end
            REQ_INVERT: begin
              order_max <= !order_max;
              cur <= count >> 1;
              lim <= count >> 1;
            end
            default: if (rid <= IdBits'(Capacity) && mslot != '0 && mslot <= count) begin
              qfound <= 1'b1;
              qkey <= key_mem[AddrBits'(mslot - 1'b1)];
            end
          endcase
        end
        S_POPLAST: begin
          id_mem[0] <= cid;
          key_mem[0] <= ckey;
          map_mem[cid] <= SlotBits'(1);
          count <= count - 1'b1;
        end
        S_POPMAP: begin
          if (bid != cid) map_mem[bid] <= '0; else map_mem[bid] <= '0;
          cur <= SlotBits'(1);
          lim <= '0;
        end
        S_UPRD: if (cur > SlotBits'(1)) begin
          bid <= id_mem[AddrBits'((cur >> 1) - 1'b1)];
          bkey <= key_mem[AddrBits'((cur >> 1) - 1'b1)];
          chl <= cur >> 1;
        end
        S_DNRD: begin
          // phase 0 reads node, 1 left child, 2 right child, 3 picks the child
          case (phase)
            2'd0: begin
              aid <= id_mem[AddrBits'(cur - 1'b1)];
              akey <= key_mem[AddrBits'(cur - 1'b1)];
              if ({cur, 1'b0} <= {1'b0, count}) phase <= 2'd1;
            end
            2'd1: begin
              bid <= id_mem[AddrBits'({cur, 1'b0} - 1'b1)];
              bkey <= key_mem[AddrBits'({cur, 1'b0} - 1'b1)];
              chl <= SlotBits'({cur, 1'b0});
              if ({cur, 1'b0} < {1'b0, count}) phase <= 2'd2;
              else phase <= 2'd0;
            end
            2'd2: begin
              cid <= id_mem[AddrBits'({cur, 1'b0})];
              ckey <= key_mem[AddrBits'({cur, 1'b0})];
              phase <= 2'd3;
            end
            default: begin
              if (above(order_max, ckey, bkey)) begin
                bid <= cid;
                bkey <= ckey;
                chl <= SlotBits'({cur, 1'b0}) + 1'b1;
              end
              phase <= 2'd0;
            end
          endcase
        end
        S_SWAP: begin
          id_mem[AddrBits'(cur - 1'b1)] <= bid;
          key_mem[AddrBits'(cur - 1'b1)] <= bkey;
          id_mem[AddrBits'(chl - 1'b1)] <= aid;
          key_mem[AddrBits'(chl - 1'b1)] <= akey;
          map_mem[bid] <= cur;
          map_mem[aid] <= chl;
          cur <= chl;
        end
        S_INVNEXT: if (req == REQ_INVERT && lim > SlotBits'(1)) begin
          lim <= lim - 1'b1;
          cur <= lim - 1'b1;
        end
        S_RESULT: if (res_load) begin
          out_data <= {5'd0, qkey, qfound, order_max, count, (count == '0),
                       (count != '0) ? key_mem[0] : '0,
                       (count != '0) ? id_mem[0] : '0, status};
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = out_data;
endmodule
`default_nettype wire

### src/ibhq_checker.sv
// Port-level checker for the heap queue, bound to the top level
`default_nettype none
`include "indexed_binary_heap_queue_macros.svh"
module ibhq_checker
  import ibhq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [87:0] m_tdata
);
  `IBHQ_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `IBHQ_ASSERT_NEXT(a_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `IBHQ_ASSERT_IMPL(a_empty, clk, rst, m_tvalid && m_tdata[41], m_tdata[48:42] == 7'd0)
  `IBHQ_ASSERT_NEXT(a_accept, clk, rst, s_tvalid && s_tready, !s_tready)
endmodule
bind indexed_binary_heap_queue ibhq_checker u_chk (.*);
`default_nettype wire
